[hdl/bfs_pkg.sv]
package bfs_pkg;

  // Store geometry
  localparam int STORE_BYTES    = 256;
  localparam int ADDR_W         = $clog2(STORE_BYTES);
  localparam int MAX_FIELD_BITS = 64;

  // Field widths of the channels
  localparam int POS_W  = 11;
  localparam int LEN_W  = 7;
  localparam int VAL_W  = 64;
  localparam int USED_W = 9;

  // Byte walk: a field of MAX_FIELD_BITS bits at any bit offset touches at most this many bytes
  localparam int SPAN_BYTES = MAX_FIELD_BITS / 8 + 1;
  localparam int ACC_W      = SPAN_BYTES * 8;
  localparam int CNT_W      = $clog2(SPAN_BYTES + 1);
  localparam int LAST_W     = POS_W + 1;
  localparam int BIDX_W     = LAST_W - 3;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_ZERO_LEN = 3'd2,
    ST_PAST_USE = 3'd3,
    ST_TOO_WIDE = 3'd4,
    ST_PAST_CAP = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    byte_t             wr_data;
  } store_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  read_value;
    status_t           status;
    logic [USED_W-1:0] used_bytes;
  } result_t;

  // Ones in the low len bits; a length of VAL_W or more gives all ones.
  function automatic logic [VAL_W-1:0] field_mask(input logic [LEN_W-1:0] len);
    logic [VAL_W:0] one_sh;
    one_sh = (VAL_W + 1)'(1) << len;
    return one_sh[VAL_W-1:0] - VAL_W'(1);
  endfunction

endpackage

[hdl/bfs_in_if.sv]
interface bfs_in_if;
  import bfs_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [POS_W-1:0]  bit_position;
  logic [LEN_W-1:0]  field_length;
  logic [VAL_W-1:0]  write_value;

  modport source (output valid, output operation, output bit_position,
                  output field_length, output write_value, input ready);
  modport sink   (input valid, input operation, input bit_position,
                  input field_length, input write_value, output ready);
endinterface

[hdl/bfs_out_if.sv]
interface bfs_out_if;
  import bfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  read_value;
  logic [2:0]        status;
  logic [USED_W-1:0] used_bytes;

  modport source (output valid, output read_value, output status,
                  output used_bytes, input ready);
  modport sink   (input valid, input read_value, input status,
                  input used_bytes, output ready);
endinterface

[hdl/bfs_store.sv]
module bfs_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfs_pkg::store_req_t   req,
  output bfs_pkg::byte_t        rd_data
);
  import bfs_pkg::*;

  byte_t                  mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_r;
  byte_t                  data_r;
  logic                   hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    data_r <= mem[req.rd_addr];
  end

  // Bytes never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      hit_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = hit_r ? data_r : '0;

endmodule

[hdl/bfs_seq.sv]
module bfs_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  bfs_in_if.sink               in_ch,
  output bfs_pkg::store_req_t  st_req,
  input  bfs_pkg::byte_t       st_rdata,
  output bfs_pkg::result_t     res,
  output logic                 res_valid,
  input  logic                 res_take
);
  import bfs_pkg::*;

  state_t             state_r, state_nxt;
  logic               op_r;
  logic [POS_W-1:0]   pos_r;
  logic [LEN_W-1:0]   len_r;
  logic [VAL_W-1:0]   val_r;
  logic [USED_W-1:0]  used_r;
  status_t            st_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   d_r;
  logic [ACC_W-1:0]   m_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [LAST_W-1:0]  last_bit;
  logic [BIDX_W-1:0]  last_byte;
  logic [USED_W-1:0]  need;
  logic [VAL_W-1:0]   len_mask;
  logic [ADDR_W-1:0]  first_byte;
  logic [2:0]         bit_off;
  status_t            chk_status;
  logic               accept;

  assign accept     = in_ch.valid && in_ch.ready;
  assign last_bit   = LAST_W'(pos_r) + LAST_W'(len_r) - LAST_W'(1);
  assign last_byte  = last_bit[LAST_W-1:3];
  assign need       = USED_W'(last_byte) + USED_W'(1);
  assign len_mask   = field_mask(len_r);
  assign first_byte = ADDR_W'(pos_r >> 3);
  assign bit_off    = pos_r[2:0];

  always_comb begin
    chk_status = ST_OK;
    if (op_r == OP_READ) begin
      if (used_r == '0) begin
        chk_status = ST_EMPTY;
      end else if (len_r == '0) begin
        chk_status = ST_ZERO_LEN;
      end else if (len_r > LEN_W'(MAX_FIELD_BITS)) begin
        chk_status = ST_TOO_WIDE;
      end else if (USED_W'(last_byte) >= used_r) begin
        chk_status = ST_PAST_USE;
      end
    end else begin
      if (len_r == '0) begin
        chk_status = ST_ZERO_LEN;
      end else if (len_r > LEN_W'(MAX_FIELD_BITS)) begin
        chk_status = ST_TOO_WIDE;
      end else if ((val_r & ~len_mask) != '0) begin
        chk_status = ST_TOO_WIDE;
      end else if ((BIDX_W + 1)'(last_byte) >= (BIDX_W + 1)'(STORE_BYTES)) begin
        chk_status = ST_PAST_CAP;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (chk_status == ST_OK) ? S_WALK : S_FINISH;
      S_WALK:   if (cnt_r == CNT_W'(SPAN_BYTES)) state_nxt = S_FINISH;
      S_FINISH: if (res_take) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ch.ready    = (state_r == S_IDLE);
    res_valid      = (state_r == S_FINISH);
    st_req.rd_addr = first_byte + ADDR_W'(cnt_r);
    st_req.wr_addr = first_byte + ADDR_W'(cnt_r - CNT_W'(1));
    st_req.wr_data = (st_rdata & ~m_r[7:0]) | (d_r[7:0] & m_r[7:0]);
    st_req.wr_en   = (state_r == S_WALK) && (cnt_r != '0) && (op_r == OP_WRITE)
                     && (m_r[7:0] != '0);
    res.status     = st_r;
    res.used_bytes = used_r;
    res.read_value = '0;
    if (op_r == OP_READ && st_r == ST_OK) begin
      res.read_value = len_mask & VAL_W'(acc_r >> bit_off);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CHECK && chk_status == ST_OK && op_r == OP_WRITE
          && need > used_r) begin
        used_r <= need;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_r  <= in_ch.operation;
          pos_r <= in_ch.bit_position;
          len_r <= in_ch.field_length;
          val_r <= in_ch.write_value;
        end
      end
      S_CHECK: begin
        st_r  <= chk_status;
        cnt_r <= '0;
        d_r   <= ACC_W'(val_r) << bit_off;
        m_r   <= ACC_W'(len_mask) << bit_off;
      end
      S_WALK: begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          acc_r <= {st_rdata, acc_r[ACC_W-1:8]};
          d_r   <= d_r >> 8;
          m_r   <= m_r >> 8;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/bit_field_store_insert_extract_top.sv]
// Bit-field store: a byte-organized bit string with field insert and extract.
// Bit 0 of the string is the lsb of byte 0. One input beat on in_ch carries an
// operation (read or write), a bit position, a field length of 1 to 64 bits and,
// for writes, the right-aligned value. Every input beat yields exactly one beat
// on out_ch: the field right-aligned (zero on writes and errors), a status code
// and the number of bytes in use after the operation.
// Flow: an accepted beat first passes a check state, then walks the spanned
// bytes through the byte store (one read and one write port), one byte per cycle
// over a fixed window of nine bytes; the store's read data is registered. A
// final state then hands the result to the output register. An item that fails
// the checks skips the walk. in_ch.ready is high only while no item is in
// flight, so the next beat can be taken the cycle after the result is loaded; it
// may be taken while that result still waits on out_ch.
// Reset (rst_n low, synchronous) empties the store: the in-use count clears and
// every byte reads as zero until written. A stall on out_ch holds the result
// register; a finished item then waits in its last step until the register frees.
module bit_field_store_insert_extract_top (
  input  logic       clk,
  input  logic       rst_n,
  bfs_in_if.sink     in_ch,
  bfs_out_if.source  out_ch
);
  import bfs_pkg::*;

  store_req_t st_req;
  byte_t      st_rdata;
  result_t    res;
  logic       res_valid;
  logic       res_take;
  logic       out_valid_r;
  result_t    out_res_r;

  bfs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .st_req    (st_req),
    .st_rdata  (st_rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  bfs_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_data (st_rdata)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload while the beat is stalled.
  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_res_r.read_value;
  assign out_ch.status     = out_res_r.status;
  assign out_ch.used_bytes = out_res_r.used_bytes;

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_take |=> out_valid_r)
    else $error("finished result not presented on out_ch");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_OK |-> out_res_r.read_value == '0)
    else $error("nonzero read value on an error");

  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.used_bytes <= USED_W'(STORE_BYTES))
    else $error("bytes in use beyond capacity");

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.wr_en |-> !in_ch.ready && !res_valid)
    else $error("store written outside the byte walk");
`endif

endmodule
